>>> rtl/atilt_pkg.sv
// Shared types, widths and the arctangent table for the tilt-angle block.
// No dependencies; every other file in rtl imports this package.
package atilt_pkg;

	localparam int WORD_W = 16;
	localparam int RAW_W = 16;
	localparam int OTHER_W = RAW_W + 1;
	localparam int SUM_W = 32;
	localparam int OPND_FRAC = 12;
	localparam int ROOT_W = 28;
	localparam int REM_W = 57;
	localparam int CW = 32;
	localparam int ZW = 32;
	localparam int TBL_LEN = 24;
	localparam int TBL_FRAC = 24;
	localparam int ANGLE_W = 16;
	localparam int FRONT_STAGES = 3;

	localparam int DEF_ANGLE_FRAC_BITS = 8;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int DEF_RAW_SHIFT = 6;

	// atan(2^-i) in degrees, Q24
	localparam logic [ZW-1:0] ATAN_TBL [TBL_LEN] = '{
		32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
		32'd60000934, 32'd30029717, 32'd15018523, 32'd7509720,
		32'd3754917, 32'd1877466, 32'd938734, 32'd469367,
		32'd234684, 32'd117342, 32'd58671, 32'd29335,
		32'd14668, 32'd7334, 32'd3667, 32'd1833,
		32'd917, 32'd458, 32'd229, 32'd115
	};

	typedef enum logic [1:0] {
		SEL_CORDIC,
		SEL_ZERO,
		SEL_POS,
		SEL_NEG
	} sel_t;

	typedef struct packed {
		sel_t sel;
		logic neg;
		logic undef;
	} lane_ctl_t;

	typedef struct packed {
		lane_ctl_t ctl;
		logic signed [OTHER_W-1:0] other;
	} sq_side_t;

endpackage

>>> rtl/atilt_sqrt_cell.sv
// One bit of a pipelined restoring square root, remainder form.
// Depends on atilt_pkg.
module atilt_sqrt_cell #(
	parameter int K = 0
) (
	input  logic clk,
	input  logic en,
	input  logic [atilt_pkg::REM_W-1:0] rem_in,
	input  logic [atilt_pkg::ROOT_W-1:0] root_in,
	input  atilt_pkg::sq_side_t side_in,
	output logic [atilt_pkg::REM_W-1:0] rem_q,
	output logic [atilt_pkg::ROOT_W-1:0] root_q,
	output atilt_pkg::sq_side_t side_q
);
	import atilt_pkg::*;

	logic [REM_W-1:0] trial;

	// (r + 2^k)^2 - r^2
	assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));

	always_ff @(posedge clk) begin
		if (en) begin
			side_q <= side_in;
			if (rem_in >= trial) begin
				rem_q <= rem_in - trial;
				root_q <= root_in | (ROOT_W'(1) << K);
			end else begin
				rem_q <= rem_in;
				root_q <= root_in;
			end
		end
	end

endmodule

>>> rtl/atilt_cordic_cell.sv
// One vectoring CORDIC micro-rotation with degree accumulation.
// Depends on atilt_pkg.
module atilt_cordic_cell #(
	parameter int I = 0
) (
	input  logic clk,
	input  logic en,
	input  logic signed [atilt_pkg::CW-1:0] x_in,
	input  logic signed [atilt_pkg::CW-1:0] y_in,
	input  logic signed [atilt_pkg::ZW-1:0] z_in,
	input  atilt_pkg::lane_ctl_t ctl_in,
	output logic signed [atilt_pkg::CW-1:0] x_q,
	output logic signed [atilt_pkg::CW-1:0] y_q,
	output logic signed [atilt_pkg::ZW-1:0] z_q,
	output atilt_pkg::lane_ctl_t ctl_q
);
	import atilt_pkg::*;

	logic signed [CW-1:0] xs;
	logic signed [CW-1:0] ys;
	logic signed [ZW-1:0] ang;

	assign xs = x_in >>> I;
	assign ys = y_in >>> I;
	assign ang = $signed(ATAN_TBL[I]);

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_q <= ctl_in;
			if (!y_in[CW-1]) begin
				x_q <= x_in + ys;
				y_q <= y_in - xs;
				z_q <= z_in + ang;
			end else begin
				x_q <= x_in - ys;
				y_q <= y_in + xs;
				z_q <= z_in - ang;
			end
		end
	end

endmodule

>>> rtl/atilt_lane.sv
// One angle: square-root cell chain, CORDIC cell chain, rounding and clamp.
// Depends on atilt_pkg, atilt_sqrt_cell and atilt_cordic_cell.
module atilt_lane #(
	parameter int ANGLE_FRAC_BITS = atilt_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES = atilt_pkg::DEF_CORDIC_STAGES,
	parameter bit MAG_IS_NUM = 1'b0
) (
	input  logic clk,
	input  logic en,
	input  logic [atilt_pkg::SUM_W-1:0] sum_in,
	input  atilt_pkg::sq_side_t side_in,
	output logic [atilt_pkg::ANGLE_W-1:0] angle_q,
	output logic undef_q
);
	import atilt_pkg::*;

	localparam int NC = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
	localparam int DROP = TBL_FRAC - ANGLE_FRAC_BITS;
	localparam int FW = ZW + 1;

	logic [REM_W-1:0] rem [ROOT_W+1];
	logic [ROOT_W-1:0] root [ROOT_W+1];
	sq_side_t side [ROOT_W+1];

	logic signed [CW-1:0] cx [NC+1];
	logic signed [CW-1:0] cy [NC+1];
	logic signed [ZW-1:0] cz [NC+1];
	lane_ctl_t cctl [NC+1];

	logic signed [CW-1:0] mag_op;
	logic signed [CW-1:0] ax_op;
	logic signed [FW-1:0] right;
	logic signed [FW-1:0] rnd;
	logic signed [FW-1:0] clamped;
	logic signed [FW-1:0] picked;

	assign rem[0] = REM_W'(sum_in) << (2 * OPND_FRAC);
	assign root[0] = '0;
	assign side[0] = side_in;

	for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
		atilt_sqrt_cell #(.K(ROOT_W - 1 - j)) u_cell (
			.clk(clk), .en(en),
			.rem_in(rem[j]), .root_in(root[j]), .side_in(side[j]),
			.rem_q(rem[j+1]), .root_q(root[j+1]), .side_q(side[j+1])
		);
	end

	assign mag_op = $signed(CW'(root[ROOT_W]));
	assign ax_op = CW'(side[ROOT_W].other) <<< OPND_FRAC;

	assign cx[0] = MAG_IS_NUM ? ax_op : mag_op;
	assign cy[0] = MAG_IS_NUM ? mag_op : ax_op;
	assign cz[0] = '0;
	assign cctl[0] = side[ROOT_W].ctl;

	for (genvar i = 0; i < NC; i++) begin : g_cordic
		atilt_cordic_cell #(.I(i)) u_cell (
			.clk(clk), .en(en),
			.x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]), .ctl_in(cctl[i]),
			.x_q(cx[i+1]), .y_q(cy[i+1]), .z_q(cz[i+1]), .ctl_q(cctl[i+1])
		);
	end

	// round half up, clamp to a right angle, then the special cases
	assign right = FW'(90) <<< ANGLE_FRAC_BITS;
	assign rnd = (FW'(cz[NC]) + (FW'(1) <<< (DROP - 1))) >>> DROP;

	always_comb begin
		if (rnd > right) begin
			clamped = right;
		end else if (rnd < -right) begin
			clamped = -right;
		end else begin
			clamped = rnd;
		end
		case (cctl[NC].sel)
			SEL_ZERO: picked = '0;
			SEL_POS:  picked = right;
			SEL_NEG:  picked = -right;
			default:  picked = clamped;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_q <= cctl[NC].neg ? ANGLE_W'(-picked) : ANGLE_W'(picked);
			undef_q <= cctl[NC].undef;
		end
	end

endmodule

>>> rtl/accel_tilt_angles.sv
// Top level of the accelerometer tilt-angle block.
// Depends on atilt_pkg and atilt_lane (and through it on the cell modules).
//
// Usage: one sample is three left-justified 16-bit axis words on the input
// channel (in_valid / in_stall). A transfer takes place at a rising clk edge
// with valid high and stall low. Each sample yields one result on the output
// channel (out_valid / out_stall): pitch, roll and incline in degrees with
// ANGLE_FRAC_BITS fraction bits, and undefined_flag for an all-zero sample.
// The pipeline: three front stages (shift, squares, sums), 28 square-root
// cells (one root bit each), one CORDIC cell per stage, and the
// rounding/output register. Throughput is one sample per clock while the
// receiver does not stall; the three angles run in parallel lanes.
// When the receiver stalls a waiting result the whole pipeline holds and the
// input stalls, so nothing is lost; empty slots are not squeezed out while
// held, they only move on once the result moves. Reset (arst_n low) clears
// the valid bits only; the data path needs none.
module accel_tilt_angles #(
	parameter int ANGLE_FRAC_BITS = atilt_pkg::DEF_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES = atilt_pkg::DEF_CORDIC_STAGES,
	parameter int RAW_SHIFT = atilt_pkg::DEF_RAW_SHIFT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [atilt_pkg::WORD_W-1:0] axis_x_word,
	input  logic signed [atilt_pkg::WORD_W-1:0] axis_y_word,
	input  logic signed [atilt_pkg::WORD_W-1:0] axis_z_word,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [atilt_pkg::ANGLE_W-1:0] pitch_angle,
	output logic signed [atilt_pkg::ANGLE_W-1:0] roll_angle,
	output logic signed [atilt_pkg::ANGLE_W-1:0] incline_angle,
	output logic undefined_flag
);
	import atilt_pkg::*;

	localparam int NC = (CORDIC_STAGES < TBL_LEN) ? CORDIC_STAGES : TBL_LEN;
	localparam int LAT = FRONT_STAGES + ROOT_W + NC + 1;
	localparam int RIGHT = 90 * (2 ** ANGLE_FRAC_BITS);
	localparam bit RIGHT_FITS = RIGHT < (2 ** (ANGLE_W - 1));

	logic en;
	logic [LAT-1:0] vld_q;

	// stage 1: raw axis values
	logic signed [RAW_W-1:0] x_s1, y_s1, z_s1;
	// stage 2: squares and lane control
	logic [SUM_W-1:0] xx_s2, yy_s2, zz_s2;
	sq_side_t pside_s2, rside_s2, iside_s2;
	// stage 3: sums of squares
	logic [SUM_W-1:0] psum_s3, rsum_s3, isum_s3;
	sq_side_t pside_s3, rside_s3, iside_s3;

	logic p_undef, r_undef, i_undef;
	logic x0, y0, z0, all0;

	// pipeline moves unless a finished result is held by the receiver
	assign en = !(vld_q[LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= axis_x_word >>> RAW_SHIFT;
			y_s1 <= axis_y_word >>> RAW_SHIFT;
			z_s1 <= axis_z_word >>> RAW_SHIFT;
		end
	end

	assign x0 = (x_s1 == '0);
	assign y0 = (y_s1 == '0);
	assign z0 = (z_s1 == '0);
	assign all0 = x0 && y0 && z0;

	always_ff @(posedge clk) begin
		if (en) begin
			// operands widened first so the square keeps all its bits
			xx_s2 <= $unsigned(SUM_W'(x_s1) * SUM_W'(x_s1));
			yy_s2 <= $unsigned(SUM_W'(y_s1) * SUM_W'(y_s1));
			zz_s2 <= $unsigned(SUM_W'(z_s1) * SUM_W'(z_s1));

			// pitch: x over the y/z magnitude
			pside_s2.other <= OTHER_W'(x_s1);
			pside_s2.ctl.neg <= 1'b0;
			pside_s2.ctl.undef <= all0;
			if (x0) begin
				pside_s2.ctl.sel <= SEL_ZERO;
			end else if (y0 && z0) begin
				pside_s2.ctl.sel <= x_s1[RAW_W-1] ? SEL_NEG : SEL_POS;
			end else begin
				pside_s2.ctl.sel <= SEL_CORDIC;
			end

			// roll: y over the x/z magnitude
			rside_s2.other <= OTHER_W'(y_s1);
			rside_s2.ctl.neg <= 1'b0;
			rside_s2.ctl.undef <= all0;
			if (y0) begin
				rside_s2.ctl.sel <= SEL_ZERO;
			end else if (x0 && z0) begin
				rside_s2.ctl.sel <= y_s1[RAW_W-1] ? SEL_NEG : SEL_POS;
			end else begin
				rside_s2.ctl.sel <= SEL_CORDIC;
			end

			// incline: x/y magnitude over |z|, sign of z applied at the end
			iside_s2.other <= z_s1[RAW_W-1] ? -OTHER_W'(z_s1) : OTHER_W'(z_s1);
			iside_s2.ctl.neg <= z_s1[RAW_W-1];
			iside_s2.ctl.undef <= all0;
			if (x0 && y0) begin
				iside_s2.ctl.sel <= SEL_ZERO;
			end else if (z0) begin
				iside_s2.ctl.sel <= SEL_POS;
			end else begin
				iside_s2.ctl.sel <= SEL_CORDIC;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			psum_s3 <= yy_s2 + zz_s2;
			rsum_s3 <= xx_s2 + zz_s2;
			isum_s3 <= xx_s2 + yy_s2;
			pside_s3 <= pside_s2;
			rside_s3 <= rside_s2;
			iside_s3 <= iside_s2;
		end
	end

	atilt_lane #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .MAG_IS_NUM(1'b0)
	) u_pitch (
		.clk(clk), .en(en), .sum_in(psum_s3), .side_in(pside_s3),
		.angle_q(pitch_angle), .undef_q(p_undef)
	);

	atilt_lane #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .MAG_IS_NUM(1'b0)
	) u_roll (
		.clk(clk), .en(en), .sum_in(rsum_s3), .side_in(rside_s3),
		.angle_q(roll_angle), .undef_q(r_undef)
	);

	atilt_lane #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STAGES(CORDIC_STAGES), .MAG_IS_NUM(1'b1)
	) u_incline (
		.clk(clk), .en(en), .sum_in(isum_s3), .side_in(iside_s3),
		.angle_q(incline_angle), .undef_q(i_undef)
	);

	assign undefined_flag = p_undef | r_undef | i_undef;

	// an all-zero sample gives zero angles
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && undefined_flag) |->
		(pitch_angle == '0 && roll_angle == '0 && incline_angle == '0))
		else $error("undefined sample with nonzero angle");

	// angles never exceed a right angle when that fits the field
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && RIGHT_FITS) |->
		(int'(pitch_angle) <= RIGHT && int'(pitch_angle) >= -RIGHT &&
		 int'(roll_angle) <= RIGHT && int'(roll_angle) >= -RIGHT &&
		 int'(incline_angle) <= RIGHT && int'(incline_angle) >= -RIGHT))
		else $error("angle beyond ninety degrees");

	// a held result keeps the whole valid pipeline frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid pipeline moved while stalled");

	// every transfer in enters the first valid bit
	a_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> vld_q[0])
		else $error("accepted sample lost at entry");

endmodule

>>> tb/tb.sv
// Self-checking testbench for accel_tilt_angles: directed samples, then random samples.
// Depends on atilt_pkg and the RTL top level; expected angles come from an in-bench predictor.
`timescale 1ns / 100ps

module tb;
	import atilt_pkg::*;

	localparam int FRAC = DEF_ANGLE_FRAC_BITS;
	localparam int STAGES = (DEF_CORDIC_STAGES < TBL_LEN) ? DEF_CORDIC_STAGES : TBL_LEN;
	localparam int SHIFT = DEF_RAW_SHIFT;
	localparam int LATENCY = 3 + 28 + DEF_CORDIC_STAGES + 1;

	typedef struct packed {
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] roll;
		logic [ANGLE_W-1:0] incline;
		logic undef;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [WORD_W-1:0] axis_x_word = '0;
	logic signed [WORD_W-1:0] axis_y_word = '0;
	logic signed [WORD_W-1:0] axis_z_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [ANGLE_W-1:0] pitch_angle;
	logic signed [ANGLE_W-1:0] roll_angle;
	logic signed [ANGLE_W-1:0] incline_angle;
	logic undefined_flag;

	tilt_t pending_angles[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_req = 0;
	int hold_left = 0;

	accel_tilt_angles dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.axis_x_word(axis_x_word), .axis_y_word(axis_y_word), .axis_z_word(axis_z_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.pitch_angle(pitch_angle), .roll_angle(roll_angle),
		.incline_angle(incline_angle), .undefined_flag(undefined_flag)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// bitwise integer square root, floor
	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// vectoring CORDIC angle of num/den in degrees, den >= 0
	function automatic longint atan_deg(longint num, longint den, inout bit undef);
		longint right;
		longint cx, cy, cz, xs, ys, r;
		right = longint'(90) <<< FRAC;
		if (den == 0) begin
			if (num == 0) begin
				undef = 1'b1;
				return 0;
			end
			return (num > 0) ? right : -right;
		end
		if (num == 0)
			return 0;
		cx = den;
		cy = num;
		cz = 0;
		for (int i = 0; i < STAGES; i++) begin
			xs = cx >>> i;
			ys = cy >>> i;
			if (cy >= 0) begin
				cx += ys;
				cy -= xs;
				cz += longint'(ATAN_TBL[i]);
			end else begin
				cx -= ys;
				cy += xs;
				cz -= longint'(ATAN_TBL[i]);
			end
		end
		r = (cz + (longint'(1) <<< (TBL_FRAC - FRAC - 1))) >>> (TBL_FRAC - FRAC);
		if (r > right)
			r = right;
		if (r < -right)
			r = -right;
		return r;
	endfunction

	function automatic tilt_t predict_tilt(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
		longint x, y, z, mag, incl;
		longint unsigned sq;
		bit undef;
		tilt_t t;
		x = longint'($signed(wx)) >>> SHIFT;
		y = longint'($signed(wy)) >>> SHIFT;
		z = longint'($signed(wz)) >>> SHIFT;
		undef = 1'b0;
		sq = longint'(y * y + z * z);
		mag = longint'(int_sqrt(sq << (2 * OPND_FRAC)));
		t.pitch = ANGLE_W'(atan_deg(x <<< OPND_FRAC, mag, undef));
		sq = longint'(x * x + z * z);
		mag = longint'(int_sqrt(sq << (2 * OPND_FRAC)));
		t.roll = ANGLE_W'(atan_deg(y <<< OPND_FRAC, mag, undef));
		sq = longint'(x * x + y * y);
		mag = longint'(int_sqrt(sq << (2 * OPND_FRAC)));
		incl = atan_deg(mag, ((z < 0) ? -z : z) <<< OPND_FRAC, undef);
		if (z < 0)
			incl = -incl;
		t.incline = ANGLE_W'(incl);
		t.undef = undef;
		return t;
	endfunction

	// offer one sample, with random idle cycles first; valid drops only during idle cycles
	task automatic send_sample(logic [15:0] wx, logic [15:0] wy, logic [15:0] wz);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		axis_x_word <= wx;
		axis_y_word <= wy;
		axis_z_word <= wz;
		do
			@(posedge clk);
		while (in_stall);
		pending_angles.push_back(predict_tilt(wx, wy, wz));
		sent++;
	endtask

	// receiver stall: random, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// result checker: every transfer on the output side is matched against the oldest prediction
	always @(posedge clk) begin
		tilt_t exp_t;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_angles.size() == 0) begin
				$display("%0t: unexpected result p=%h r=%h i=%h u=%b", $time,
					pitch_angle, roll_angle, incline_angle, undefined_flag);
				errors++;
			end else begin
				exp_t = pending_angles.pop_front();
				checked++;
				if (pitch_angle !== exp_t.pitch) begin
					$display("%0t: pitch expected %h actual %h", $time, exp_t.pitch, pitch_angle);
					errors++;
				end
				if (roll_angle !== exp_t.roll) begin
					$display("%0t: roll expected %h actual %h", $time, exp_t.roll, roll_angle);
					errors++;
				end
				if (incline_angle !== exp_t.incline) begin
					$display("%0t: incline expected %h actual %h", $time,
						exp_t.incline, incline_angle);
					errors++;
				end
				if (undefined_flag !== exp_t.undef) begin
					$display("%0t: undef expected %b actual %b", $time,
						exp_t.undef, undefined_flag);
					errors++;
				end
			end
		end
	end

	function automatic logic [15:0] rand_word();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'(int'($urandom_range(127)) - 64);
			2: return {$urandom_range(1) ? 10'h3FF : 10'h000, 6'($urandom)};
			default: return 16'($urandom);
		endcase
	endfunction

	// extremes, single axes, zero sample and words that shift down to zero
	task automatic test_directed();
		send_sample(16'h0000, 16'h0000, 16'h0000);
		send_sample(16'h003F, 16'h0020, 16'h0001);
		send_sample(16'h4000, 16'h0000, 16'h0000);
		send_sample(16'hC000, 16'h0000, 16'h0000);
		send_sample(16'h0000, 16'h4000, 16'h0000);
		send_sample(16'h0000, 16'hC000, 16'h0000);
		send_sample(16'h0000, 16'h0000, 16'h4000);
		send_sample(16'h0000, 16'h0000, 16'hC000);
		send_sample(16'hFFFF, 16'h0000, 16'h0000);
		send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_sample(16'h8000, 16'h8000, 16'h8000);
		send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
		send_sample(16'h8000, 16'h7FFF, 16'h8000);
		send_sample(16'h0040, 16'h0040, 16'h0040);
		send_sample(16'hFFC0, 16'hFFC0, 16'hFFC0);
		send_sample(16'h0000, 16'h0000, 16'h7FFF);
		send_sample(16'h7FFF, 16'h0000, 16'h0040);
		send_sample(16'h8000, 16'h7FFF, 16'h0000);
		send_sample(16'h5555, 16'hAAAA, 16'h5555);
		send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
	endtask

	task automatic test_random(int n, int idle_pct, int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n)
			send_sample(rand_word(), rand_word(), rand_word());
	endtask

	// receiver holds off long enough for the pipeline to fill and stall the input
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 4 * LATENCY;
		repeat (120)
			send_sample(rand_word(), rand_word(), rand_word());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(180, 0, 0);
		test_random(180, 48, 0);
		test_random(180, 0, 48);
		test_random(180, 23, 23);
		test_backpressure();
		in_valid <= 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		while (pending_angles.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		$display("Sent %0d samples (directed, random under four idle/stall mixes, hold-off).",
			sent);
		$display("Checked %0d results, %0d mismatches.", checked, errors);
		if (errors == 0 && pending_angles.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1000000;
		$display("Timeout with %0d results outstanding", pending_angles.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
